// ----- hw/rtl/thrust_setpoint_ramp_assert.svh -----
// Assertion macros shared by the thrust setpoint ramp RTL.
// Self-contained: no other file or package is needed.
`ifndef THRUST_SETPOINT_RAMP_ASSERT_SVH
`define THRUST_SETPOINT_RAMP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TSR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("thrust ramp: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TSR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("thrust ramp: next-cycle check failed");

// Condition that must hold in the cycle after a reset edge.
`define TSR_ASSERT_RST(label, clk, rst_n, cons) \
  label: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error("thrust ramp: post-reset check failed");

`endif

// ----- hw/rtl/tsr_pkg.sv -----
// Package for the thrust setpoint ramp: widths, codes, payload structs and
// clamp helpers. Used by every module of the block; depends on nothing.
package tsr_pkg;

  // Field widths.
  localparam int THR_W      = 24;
  localparam int ACC_W      = 24;
  localparam int RATE_W     = 16;
  localparam int DT_W       = 16;
  localparam int CMD_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Ramp arithmetic: Q8.8 rate times accumulated time.
  localparam int RATE_FRAC   = 8;
  localparam int RAMP_PROD_W = RATE_W + ACC_W;
  localparam int DELTA_W     = RAMP_PROD_W - RATE_FRAC;
  localparam int WIDE_W      = DELTA_W + 2;

  // Fraction path: Q1.15 times a 25-bit signed span.
  localparam int FRAC_W     = 16;
  localparam int FRAC_SHIFT = FRAC_W - 1;
  localparam int FRAC_RND   = (2 ** FRAC_SHIFT) - 1;
  localparam int MULA_W     = FRAC_W + 1;
  localparam int MULB_W     = THR_W + 1;
  localparam int FPROD_W    = MULA_W + MULB_W;
  localparam int FRAC_T_W   = FPROD_W - FRAC_SHIFT;
  localparam logic signed [THR_W-1:0] FRAC_LO = THR_W'(-(2 ** FRAC_SHIFT));
  localparam logic signed [THR_W-1:0] FRAC_HI = THR_W'((2 ** FRAC_SHIFT) - 1);

  // Target step: range / STEP_DIVISOR by reciprocal multiplication.
  localparam int STEP_DIVISOR = 20;
  localparam int STEP_W       = THR_W + 1;
  localparam int STEP_SHIFT   = THR_W + $clog2(STEP_DIVISOR);
  localparam longint unsigned STEP_RECIP =
    ((64'd1 << STEP_SHIFT) + 64'(STEP_DIVISOR) - 64'd1) / 64'(STEP_DIVISOR);
  localparam int RECIP_W      = THR_W + 1;
  localparam int SPROD_W      = THR_W + RECIP_W;

  // Command codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK       = 3'd0,
    CMD_SET_THRUST = 3'd1,
    CMD_SET_TARGET = 3'd2,
    CMD_SET_FRAC   = 3'd3,
    CMD_INC        = 3'd4,
    CMD_DEC        = 3'd5
  } cmd_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENGINE   = 3'd0,
    CFG_MIN      = 3'd1,
    CFG_MAX      = 3'd2,
    CFG_ACCEL    = 3'd3,
    CFG_INTERVAL = 3'd4
  } cfg_idx_t;

  typedef logic signed [WIDE_W-1:0] wide_t;

  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic signed [THR_W-1:0] value;
    logic [DT_W-1:0]         time_delta;
  } in_item_t;

  typedef struct packed {
    logic signed [THR_W-1:0] thrust;
    logic signed [THR_W-1:0] target_thrust;
    logic                    changed;
  } out_item_t;

  // Configuration registers plus the derived target step.
  typedef struct packed {
    logic                     engine_present;
    logic signed [THR_W-1:0]  min_thrust;
    logic signed [THR_W-1:0]  max_thrust;
    logic [RATE_W-1:0]        accel_rate;
    logic [ACC_W-1:0]         update_interval;
    logic signed [STEP_W-1:0] step;
  } cfg_t;

  // Stage-one transaction: input fields plus the precomputed fraction target.
  typedef struct packed {
    logic [CMD_W-1:0]           cmd;
    logic signed [THR_W-1:0]    value;
    logic [DT_W-1:0]            time_delta;
    logic signed [FRAC_T_W-1:0] frac;
  } s1_item_t;

  // Thrust write: raise to min first, then cap at max (max wins on overlap).
  function automatic logic signed [THR_W-1:0] thrust_clamp(
    input logic en, input wide_t v,
    input logic signed [THR_W-1:0] mn, input logic signed [THR_W-1:0] mx);
    wide_t r;
    r = v;
    if (r < wide_t'(mn)) r = wide_t'(mn);
    if (r > wide_t'(mx)) r = wide_t'(mx);
    if (!en) r = '0;
    return r[THR_W-1:0];
  endfunction

  // Target write: cap at max first, then raise to min (min wins on overlap).
  function automatic logic signed [THR_W-1:0] goal_clamp(
    input logic en, input wide_t v,
    input logic signed [THR_W-1:0] mn, input logic signed [THR_W-1:0] mx);
    wide_t r;
    r = v;
    if (r > wide_t'(mx)) r = wide_t'(mx);
    if (r < wide_t'(mn)) r = wide_t'(mn);
    if (!en) r = '0;
    return r[THR_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/tsr_cfg.sv -----
// Configuration register file of the thrust ramp and the derived target step.
// Depends on tsr_pkg.
module tsr_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [tsr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tsr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output tsr_pkg::cfg_t               cfg
);
  import tsr_pkg::*;

  cfg_t                     cfg_r;
  logic signed [THR_W:0]    span;
  logic                     span_neg;
  logic [THR_W-1:0]         span_mag;
  logic [SPROD_W-1:0]       step_prod;
  logic [SPROD_W-1:0]       step_quot;
  logic signed [STEP_W-1:0] step_nxt;

  // Step size: truncated (max - min) / STEP_DIVISOR, via magnitude and sign.
  always_comb begin
    span      = (THR_W+1)'(cfg_r.max_thrust) - (THR_W+1)'(cfg_r.min_thrust);
    span_neg  = span[THR_W];
    span_mag  = span_neg ? THR_W'(-span) : THR_W'(span);
    step_prod = SPROD_W'(span_mag) * SPROD_W'(RECIP_W'(STEP_RECIP));
    step_quot = step_prod >> STEP_SHIFT;
    step_nxt  = span_neg ? -STEP_W'({1'b0, step_quot[THR_W-1:0]})
                         : STEP_W'({1'b0, step_quot[THR_W-1:0]});
  end

  // Register writes; the step is registered from the stored range, so it follows in the cycle after a range change.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_idx_t'(cfg_index))
          CFG_ENGINE:   cfg_r.engine_present  <= cfg_wdata[0];
          CFG_MIN:      cfg_r.min_thrust      <= cfg_wdata[THR_W-1:0];
          CFG_MAX:      cfg_r.max_thrust      <= cfg_wdata[THR_W-1:0];
          CFG_ACCEL:    cfg_r.accel_rate      <= cfg_wdata[RATE_W-1:0];
          CFG_INTERVAL: cfg_r.update_interval <= cfg_wdata[ACC_W-1:0];
          default: ;
        endcase
      end
      cfg_r.step <= step_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- hw/rtl/tsr_prep.sv -----
// Input stage of the thrust ramp: takes a transaction, computes the fraction
// target (one signed multiply) and holds it for the core. Depends on tsr_pkg.
module tsr_prep (
  input  logic                clk,
  input  logic                rst_n,
  input  tsr_pkg::cfg_t       cfg,
  input  logic                in_valid,
  output logic                in_stall,
  input  tsr_pkg::in_item_t   in_data,
  input  logic                advance,
  output logic                s1_valid,
  output tsr_pkg::s1_item_t   s1_item
);
  import tsr_pkg::*;

  logic                       s1_valid_r;
  s1_item_t                   s1_item_r;
  logic                       in_take;
  logic signed [THR_W-1:0]    v_sat;
  logic signed [FRAC_W-1:0]   p_sat;
  logic                       bipolar;
  logic                       p_neg;
  logic signed [MULA_W-1:0]   mul_a;
  logic signed [MULB_W-1:0]   mul_b;
  logic signed [THR_W-1:0]    offset;
  logic signed [FPROD_W-1:0]  prod;
  logic signed [FPROD_W-1:0]  prod_adj;
  logic signed [FRAC_T_W-1:0] quot;
  logic signed [FRAC_T_W-1:0] frac_nxt;

  // The stage frees up whenever its transaction moves on to the core.
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  // Fraction target: bipolar around zero or linear across [min, max],
  // divided by 32768 with truncation toward zero.
  always_comb begin
    v_sat = in_data.value;
    if (v_sat < FRAC_LO) v_sat = FRAC_LO;
    if (v_sat > FRAC_HI) v_sat = FRAC_HI;
    p_sat   = v_sat[FRAC_W-1:0];
    p_neg   = p_sat[FRAC_W-1];
    bipolar = (cfg.min_thrust < 0) && (cfg.max_thrust > 0);
    if (bipolar) begin
      mul_a  = p_neg ? -MULA_W'(p_sat) : MULA_W'(p_sat);
      mul_b  = p_neg ? MULB_W'(cfg.min_thrust) : MULB_W'(cfg.max_thrust);
      offset = '0;
    end else begin
      mul_a  = MULA_W'(p_sat);
      mul_b  = MULB_W'(cfg.max_thrust) - MULB_W'(cfg.min_thrust);
      offset = cfg.min_thrust;
    end
    prod     = FPROD_W'(mul_a) * FPROD_W'(mul_b);
    prod_adj = prod[FPROD_W-1] ? prod + FPROD_W'(FRAC_RND) : prod;
    quot     = prod_adj[FRAC_SHIFT +: FRAC_T_W];
    frac_nxt = quot + FRAC_T_W'(offset);
  end

  // Stage-one valid bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Stage-one payload.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r.cmd        <= in_data.cmd;
      s1_item_r.value      <= in_data.value;
      s1_item_r.time_delta <= in_data.time_delta;
      s1_item_r.frac       <= frac_nxt;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_item  = s1_item_r;

endmodule

// ----- hw/rtl/tsr_core.sv -----
// State and result stage of the thrust ramp: thrust, target and interval
// accumulator, updated once per transaction. Depends on tsr_pkg.
module tsr_core (
  input  logic                clk,
  input  logic                rst_n,
  input  tsr_pkg::cfg_t       cfg,
  input  logic                s1_valid,
  input  tsr_pkg::s1_item_t   s1_item,
  output logic                advance,
  output logic                out_valid,
  input  logic                out_stall,
  output tsr_pkg::out_item_t  out_data
);
  import tsr_pkg::*;

  logic signed [THR_W-1:0] now_r, now_nxt;
  logic signed [THR_W-1:0] goal_r, goal_nxt;
  logic [ACC_W-1:0]        accum_r, accum_nxt;
  logic                    changed_r, changed_nxt;
  logic                    out_valid_r;

  logic [ACC_W:0]          acc_sum;
  logic [ACC_W-1:0]        acc_sat;
  logic                    ramp_go;
  logic [RAMP_PROD_W-1:0]  ramp_prod;
  logic [DELTA_W-1:0]      ramp_delta;
  wide_t                   now_w, goal_w, delta_w, ramp_next;

  // A transaction moves into the result register when that register is
  // empty or being read this cycle.
  assign advance = s1_valid && (!out_valid_r || !out_stall);

  // Ramp step: saturating accumulate, rate times time, stop at the target.
  always_comb begin
    acc_sum    = {1'b0, accum_r} + (ACC_W+1)'(s1_item.time_delta);
    acc_sat    = acc_sum[ACC_W] ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];
    ramp_go    = (acc_sat >= cfg.update_interval) && cfg.engine_present;
    ramp_prod  = RAMP_PROD_W'(cfg.accel_rate) * RAMP_PROD_W'(acc_sat);
    ramp_delta = ramp_prod[RATE_FRAC +: DELTA_W];
    now_w      = wide_t'(now_r);
    goal_w     = wide_t'(goal_r);
    delta_w    = wide_t'(ramp_delta);
    if (now_r < goal_r) begin
      ramp_next = (delta_w >= goal_w - now_w) ? goal_w : now_w + delta_w;
    end else begin
      ramp_next = (delta_w >= now_w - goal_w) ? goal_w : now_w - delta_w;
    end
  end

  // Command decode.
  always_comb begin
    now_nxt     = now_r;
    goal_nxt    = goal_r;
    accum_nxt   = accum_r;
    changed_nxt = 1'b0;
    case (cmd_t'(s1_item.cmd))
      CMD_TICK: begin
        if (now_r != goal_r) begin
          accum_nxt = acc_sat;
          if (ramp_go) begin
            now_nxt     = thrust_clamp(cfg.engine_present, ramp_next,
                                       cfg.min_thrust, cfg.max_thrust);
            accum_nxt   = '0;
            changed_nxt = 1'b1;
          end
        end
      end
      CMD_SET_THRUST: begin
        now_nxt     = thrust_clamp(cfg.engine_present, wide_t'(s1_item.value),
                                   cfg.min_thrust, cfg.max_thrust);
        changed_nxt = 1'b1;
      end
      CMD_SET_TARGET: begin
        goal_nxt    = goal_clamp(cfg.engine_present, wide_t'(s1_item.value),
                                 cfg.min_thrust, cfg.max_thrust);
        changed_nxt = 1'b1;
      end
      CMD_SET_FRAC: begin
        goal_nxt    = goal_clamp(cfg.engine_present, wide_t'(s1_item.frac),
                                 cfg.min_thrust, cfg.max_thrust);
        changed_nxt = 1'b1;
      end
      CMD_INC: begin
        if (cfg.engine_present) begin
          goal_nxt    = goal_clamp(1'b1, goal_w + wide_t'(cfg.step),
                                   cfg.min_thrust, cfg.max_thrust);
          changed_nxt = 1'b1;
        end
      end
      CMD_DEC: begin
        if (cfg.engine_present) begin
          goal_nxt    = goal_clamp(1'b1, goal_w - wide_t'(cfg.step),
                                   cfg.min_thrust, cfg.max_thrust);
          changed_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // State doubles as the result register: it always shows the latest item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r       <= '0;
      goal_r      <= '0;
      accum_r     <= '0;
      changed_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        now_r     <= now_nxt;
        goal_r    <= goal_nxt;
        accum_r   <= accum_nxt;
        changed_r <= changed_nxt;
      end
      out_valid_r <= advance || (out_valid_r && out_stall);
    end
  end

  assign out_valid              = out_valid_r;
  assign out_data.thrust        = now_r;
  assign out_data.target_thrust = goal_r;
  assign out_data.changed       = changed_r;

endmodule

// ----- hw/rtl/thrust_setpoint_ramp.sv -----
// Top level of the slew-rate-limited thrust setpoint.
// Depends on tsr_pkg, tsr_cfg, tsr_prep, tsr_core and the assertion header.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one command per
//   transaction: tick, set thrust, set target, set target fraction, step the
//   target up or down. Each input transaction yields exactly one result
//   transaction on out_valid / out_stall / out_data with the thrust and the
//   target after that command and a changed flag.
//   Configuration is written through cfg_wr_en / cfg_index / cfg_wdata while
//   no transaction is in flight; writes take effect at the next clock edge.
//   Stages: a command passes two register stages, the input stage and then
//   the state/result register, which it enters once that register is free.
//   Throughput: one transaction per cycle while out_stall is low. The state
//   update (saturating add, 16x24 multiply, clamp) is combinational.
//   Stall: when out_stall holds a result, the input stage still takes one
//   more transaction; after that in_stall rises until the result is read.
//   Reset (rst_n low, synchronous) clears thrust, target, accumulator, all
//   configuration registers and both valid bits.
`include "thrust_setpoint_ramp_assert.svh"

module thrust_setpoint_ramp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [tsr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tsr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  tsr_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output tsr_pkg::out_item_t             out_data
);
  import tsr_pkg::*;

  cfg_t     cfg;
  logic     s1_valid;
  s1_item_t s1_item;
  logic     advance;

  // Configuration registers and derived step.
  tsr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Input stage with the fraction multiply.
  tsr_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  // State update and result register.
  tsr_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .s1_valid  (s1_valid),
    .s1_item   (s1_item),
    .advance   (advance),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // The input side only holds off when the input stage is occupied.
  `TSR_ASSERT_IMP(a_stall_needs_full_stage, clk, rst_n, in_stall, s1_valid)
  // A staged transaction always lands in the result register when unblocked.
  `TSR_ASSERT_NXT(a_stage_drains, clk, rst_n, s1_valid && !out_stall, out_valid)
  // Reset empties both stages.
  `TSR_ASSERT_RST(a_reset_empty, clk, rst_n, !out_valid && !s1_valid)

endmodule
